/* design/mfq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfq_pkg: shared types and constants of the multi-queue FIFO manager
// Operation, status and sequencer codes, and the fixed field widths.
// ----------------------------------------------------------------------------
package mfq_pkg;

  localparam int unsigned FUNC_BITS   = 2;
  localparam int unsigned SEL_BITS    = 3;
  localparam int unsigned TAG_IO_BITS = 32;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned POS_BITS    = 6;
  localparam int unsigned CFG_BITS    = 4;

  // List stops after this many transfers.
  localparam int unsigned MAX_RESULTS = 32;

  localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_LIST   = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_POP    = 2'd2
  } mfq_func_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_QUEUE = 2'd3
  } mfq_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_POP_ADDR,
    S_POP_DONE,
    S_LIST_HEAD,
    S_LIST_WALK
  } mfq_state_e;

  // Write enables into the entry pool.
  typedef struct packed {
    logic link;
    logic tag;
  } mfq_pool_we_t;

endpackage

/* design/mfq_pool.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfq_pool: shared entry pool
// Link and tag memories with one registered read port; unwritten links
// read as the free-list chain order.
// ----------------------------------------------------------------------------
module mfq_pool #(
  parameter int unsigned POOL_ENTRIES = 32,
  parameter int unsigned TAG_BITS     = 32,
  localparam int unsigned EW          = $clog2(POOL_ENTRIES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [EW-1:0]        rd_addr_i,
  input  mfq_pkg::mfq_pool_we_t wr_en_i,
  input  logic [EW-1:0]        link_waddr_i,
  input  logic [EW-1:0]        link_wdata_i,
  input  logic [EW-1:0]        tag_waddr_i,
  input  logic [TAG_BITS-1:0]  tag_wdata_i,
  output logic [EW-1:0]        link_rdata_o,
  output logic [TAG_BITS-1:0]  tag_rdata_o
);

  logic [EW-1:0]           link_mem [POOL_ENTRIES];
  logic [TAG_BITS-1:0]     tag_mem  [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] link_vld_q;
  logic [EW-1:0]           chain_next;
  logic [EW-1:0]           link_rd_q;
  logic [TAG_BITS-1:0]     tag_rd_q;

  // Chain order: next entry, last one wraps to zero.
  assign chain_next = (rd_addr_i == EW'(POOL_ENTRIES - 1)) ? '0 : rd_addr_i + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
    end else if (wr_en_i.link) begin
      link_vld_q[link_waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i.link) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    link_rd_q <= link_vld_q[rd_addr_i] ? link_mem[rd_addr_i] : chain_next;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i.tag) begin
      tag_mem[tag_waddr_i] <= tag_wdata_i;
    end
    tag_rd_q <= tag_mem[rd_addr_i];
  end

  assign link_rdata_o = link_rd_q;
  assign tag_rdata_o  = tag_rd_q;

endmodule

/* design/multi_fifo_queue_manager_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_fifo_queue_manager_unit: several FIFO queues over one linked pool
// Append, pop or list a queue; entries come from a shared free list.
// ----------------------------------------------------------------------------
//
// Channel     Ports                                   Handshake
// ---------   -------------------------------------   --------------------------
// command     func_i, queue_sel_i, tag_in_i           start_i & !busy_o
// result      status_o, tag_out_o, position_o, last_o done_o, one cycle, no stall
// config      cfg_data_i                              cfg_we_i, write only
//
// A rejected command (bad queue, empty, pool full) leaves busy_o low. Append
// runs S_APPEND, pop S_POP_ADDR then S_POP_DONE, and a list S_LIST_HEAD then
// S_LIST_WALK once per entry: every step waits on the registered read port of
// the pool memories, and the list walks one link per cycle through that port.
// Each result is registered and shows in the cycle after the step that makes it.
// Reset chains the free list at once through per-entry valid bits on the
// link memory; no clearing pass. The result side cannot stall.
// ----------------------------------------------------------------------------
module multi_fifo_queue_manager_unit #(
  parameter int unsigned NUM_QUEUES   = 8,
  parameter int unsigned POOL_ENTRIES = 32,
  parameter int unsigned TAG_BITS     = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [mfq_pkg::FUNC_BITS-1:0]       func_i,
  input  logic [mfq_pkg::SEL_BITS-1:0]        queue_sel_i,
  input  logic [mfq_pkg::TAG_IO_BITS-1:0]     tag_in_i,
  input  logic                                cfg_we_i,
  input  logic [mfq_pkg::CFG_BITS-1:0]        cfg_data_i,
  output logic                                done_o,
  output logic [mfq_pkg::STATUS_BITS-1:0]     status_o,
  output logic [mfq_pkg::TAG_IO_BITS-1:0]     tag_out_o,
  output logic [mfq_pkg::POS_BITS-1:0]        position_o,
  output logic                                last_o
);

  localparam int unsigned EW  = $clog2(POOL_ENTRIES);
  localparam int unsigned QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned SW  = (QW > mfq_pkg::SEL_BITS) ? QW : mfq_pkg::SEL_BITS;
  localparam int unsigned FCW = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned LIST_LIMIT =
    (mfq_pkg::MAX_RESULTS < POOL_ENTRIES) ? mfq_pkg::MAX_RESULTS : POOL_ENTRIES;
  localparam int unsigned PW = mfq_pkg::POS_BITS;

  // Sequencer and working registers
  mfq_pkg::mfq_state_e state_q, state_d;
  logic [QW-1:0]         q_q, q_d;
  logic [EW-1:0]         cur_q, cur_d;
  logic [EW-1:0]         tail_q, tail_d;
  logic [PW-1:0]         k_q, k_d;
  logic [EW-1:0]         free_head_q, free_head_d;
  logic [FCW-1:0]        free_cnt_q, free_cnt_d;
  logic [NUM_QUEUES-1:0] nonempty_q, nonempty_d;
  logic [mfq_pkg::CFG_BITS-1:0] active_q;

  // Result register
  logic                               done_q, done_d;
  mfq_pkg::mfq_status_e               status_q, status_d;
  logic [mfq_pkg::TAG_IO_BITS-1:0]    tag_out_q, tag_out_d;
  logic [PW-1:0]                      pos_q, pos_d;
  logic                               last_q, last_d;

  // Per-queue head and tail memories
  logic [EW-1:0] head_mem [NUM_QUEUES];
  logic [EW-1:0] tail_mem [NUM_QUEUES];
  logic [EW-1:0] head_rd_q, tail_rd_q;
  logic          qt_rd_en;
  logic          head_we, tail_we;
  logic [EW-1:0] head_wdata, tail_wdata;

  // Pool port
  logic [EW-1:0]         pool_rd_addr;
  mfq_pkg::mfq_pool_we_t pool_we;
  logic [EW-1:0]         link_waddr, link_wdata;
  logic [EW-1:0]         link_rdata;
  logic [TAG_BITS-1:0]   tag_rdata;

  logic [SW-1:0] sel_ext;
  logic [QW-1:0] sel_idx;
  logic          bad_sel;
  logic          walk_stop;

  assign sel_ext = SW'(queue_sel_i);
  assign sel_idx = sel_ext[QW-1:0];
  // Reject an index at or above the active count or the built queue count.
  assign bad_sel = (mfq_pkg::CFG_BITS'(queue_sel_i) >= active_q) ||
                   (7'(queue_sel_i) >= 7'(NUM_QUEUES));

  assign walk_stop = (cur_q == tail_q) || (k_q == PW'(LIST_LIMIT - 1));

  assign busy_o = (state_q != mfq_pkg::S_IDLE);

  mfq_pool #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .TAG_BITS     (TAG_BITS)
  ) u_pool (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_addr_i    (pool_rd_addr),
    .wr_en_i      (pool_we),
    .link_waddr_i (link_waddr),
    .link_wdata_i (link_wdata),
    .tag_waddr_i  (free_head_q),
    .tag_wdata_i  (TAG_BITS'(tag_in_i)),
    .link_rdata_o (link_rdata),
    .tag_rdata_o  (tag_rdata)
  );

  // Head/tail memories: read at the command's queue on accept, write later.
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[q_q] <= head_wdata;
    end
    if (tail_we) begin
      tail_mem[q_q] <= tail_wdata;
    end
    if (qt_rd_en) begin
      head_rd_q <= head_mem[sel_idx];
      tail_rd_q <= tail_mem[sel_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfq_pkg::S_IDLE;
      free_head_q <= '0;
      free_cnt_q  <= FCW'(POOL_ENTRIES);
      nonempty_q  <= '0;
      active_q    <= mfq_pkg::ACTIVE_RESET;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      free_cnt_q  <= free_cnt_d;
      nonempty_q  <= nonempty_d;
      done_q      <= done_d;
      if (cfg_we_i) begin
        active_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    q_q       <= q_d;
    cur_q     <= cur_d;
    tail_q    <= tail_d;
    k_q       <= k_d;
    status_q  <= status_d;
    tag_out_q <= tag_out_d;
    pos_q     <= pos_d;
    last_q    <= last_d;
  end

  always_comb begin
    state_d     = state_q;
    q_d         = q_q;
    cur_d       = cur_q;
    tail_d      = tail_q;
    k_d         = k_q;
    free_head_d = free_head_q;
    free_cnt_d  = free_cnt_q;
    nonempty_d  = nonempty_q;

    done_d    = 1'b0;
    status_d  = mfq_pkg::ST_OK;
    tag_out_d = '0;
    pos_d     = '0;
    last_d    = 1'b0;

    qt_rd_en     = 1'b0;
    head_we      = 1'b0;
    tail_we      = 1'b0;
    head_wdata   = free_head_q;
    tail_wdata   = free_head_q;
    pool_rd_addr = cur_q;
    pool_we      = '0;
    link_waddr   = cur_q;
    link_wdata   = free_head_q;

    case (state_q)
      mfq_pkg::S_IDLE: begin
        if (start_i) begin
          case (mfq_pkg::mfq_func_e'(func_i))
            mfq_pkg::FUNC_LIST, mfq_pkg::FUNC_POP: begin
              if (bad_sel) begin
                done_d   = 1'b1;
                status_d = mfq_pkg::ST_BAD_QUEUE;
                last_d   = 1'b1;
              end else if (!nonempty_q[sel_idx]) begin
                done_d   = 1'b1;
                status_d = mfq_pkg::ST_EMPTY;
                last_d   = 1'b1;
              end else begin
                qt_rd_en = 1'b1;
                q_d      = sel_idx;
                state_d  = (mfq_pkg::mfq_func_e'(func_i) == mfq_pkg::FUNC_POP) ?
                           mfq_pkg::S_POP_ADDR : mfq_pkg::S_LIST_HEAD;
              end
            end
            mfq_pkg::FUNC_APPEND: begin
              if (bad_sel) begin
                done_d   = 1'b1;
                status_d = mfq_pkg::ST_BAD_QUEUE;
                last_d   = 1'b1;
              end else if (free_cnt_q == '0) begin
                done_d   = 1'b1;
                status_d = mfq_pkg::ST_FULL;
                last_d   = 1'b1;
              end else begin
                // Fetch the free head's link and store the tag in its entry.
                qt_rd_en     = 1'b1;
                q_d          = sel_idx;
                pool_rd_addr = free_head_q;
                pool_we.tag  = 1'b1;
                state_d      = mfq_pkg::S_APPEND;
              end
            end
            default: begin
              // Unused code: drop it.
            end
          endcase
        end
      end

      mfq_pkg::S_APPEND: begin
        free_head_d = link_rdata;
        free_cnt_d  = free_cnt_q - 1'b1;
        tail_we     = 1'b1;
        if (nonempty_q[q_q]) begin
          // Hook the new entry behind the old tail.
          pool_we.link = 1'b1;
          link_waddr   = tail_rd_q;
        end else begin
          head_we = 1'b1;
        end
        nonempty_d[q_q] = 1'b1;
        done_d  = 1'b1;
        last_d  = 1'b1;
        state_d = mfq_pkg::S_IDLE;
      end

      mfq_pkg::S_POP_ADDR: begin
        cur_d        = head_rd_q;
        tail_d       = tail_rd_q;
        pool_rd_addr = head_rd_q;
        state_d      = mfq_pkg::S_POP_DONE;
      end

      mfq_pkg::S_POP_DONE: begin
        done_d    = 1'b1;
        last_d    = 1'b1;
        tag_out_d = mfq_pkg::TAG_IO_BITS'(tag_rdata);
        if (cur_q == tail_q) begin
          nonempty_d[q_q] = 1'b0;
        end else begin
          head_we    = 1'b1;
          head_wdata = link_rdata;
        end
        // Return the entry to the head of the free list.
        pool_we.link = 1'b1;
        free_head_d  = cur_q;
        if (free_cnt_q < FCW'(POOL_ENTRIES)) begin
          free_cnt_d = free_cnt_q + 1'b1;
        end
        state_d = mfq_pkg::S_IDLE;
      end

      mfq_pkg::S_LIST_HEAD: begin
        cur_d        = head_rd_q;
        tail_d       = tail_rd_q;
        pool_rd_addr = head_rd_q;
        k_d          = '0;
        state_d      = mfq_pkg::S_LIST_WALK;
      end

      mfq_pkg::S_LIST_WALK: begin
        done_d    = 1'b1;
        tag_out_d = mfq_pkg::TAG_IO_BITS'(tag_rdata);
        pos_d     = k_q + 1'b1;
        last_d    = walk_stop;
        if (walk_stop) begin
          state_d = mfq_pkg::S_IDLE;
        end else begin
          // Advance along the link read for this entry.
          cur_d        = link_rdata;
          pool_rd_addr = link_rdata;
          k_d          = k_q + 1'b1;
        end
      end

      default: begin
        state_d = mfq_pkg::S_IDLE;
      end
    endcase
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign tag_out_o  = tag_out_q;
  assign position_o = pos_q;
  assign last_o     = last_q;

endmodule

/* tb/tb_multi_fifo_queue_manager_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_fifo_queue_manager_unit: self-checking bench for the queue manager
// Drives append, pop, list and unused commands through the start/busy
// handshake. A behavioral copy of the queues and the shared pool predicts
// every result, and each done_o transfer is checked field by field. A short
// directed table comes first, then pool exhaustion, then random phases under
// several settings of the active queue count.
// ----------------------------------------------------------------------------
module tb_multi_fifo_queue_manager_unit;
  import mfq_pkg::*;

  localparam int unsigned NUM_Q       = 8;
  localparam int unsigned POOL_SIZE   = 32;
  localparam int unsigned SETTLE      = 4;    // idle cycles before a register write
  localparam int unsigned DRAIN_LIMIT = 4000; // cycles allowed for the last results
  localparam int unsigned END_QUIET   = 50;   // idle cycles at the end; outlasts a full-pool list
  localparam int unsigned MAX_REPORTS = 40;
  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    mfq_status_e           status;
    logic [TAG_IO_BITS-1:0] tag;
    logic [POS_BITS-1:0]   pos;
    logic                  last;
  } q_result_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0]   func;
    logic [SEL_BITS-1:0]    qsel;
    logic [TAG_IO_BITS-1:0] tag;
    logic                   typed;  // want holds the expected result
    q_result_t              want;
  } cmd_row_t;

  // Directed commands. Rows with typed set carry their result by hand; the
  // others (multi-entry lists, ignored opcodes) go through the predictor.
  localparam int N_DIRECTED = 20;
  localparam cmd_row_t DIRECTED[N_DIRECTED] = '{
    '{FUNC_LIST,   3'd0, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0,         6'd0, 1'b1}},
    '{FUNC_POP,    3'd7, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0,         6'd0, 1'b1}},
    '{FUNC_UNUSED, 3'd0, 32'hFFFF_FFFF, 1'b0, '{ST_OK,    32'h0,         6'd0, 1'b0}},
    '{FUNC_APPEND, 3'd0, 32'h0000_0000, 1'b1, '{ST_OK,    32'h0,         6'd0, 1'b1}},
    '{FUNC_APPEND, 3'd0, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0,         6'd0, 1'b1}},
    '{FUNC_APPEND, 3'd7, 32'hA5A5_A5A5, 1'b1, '{ST_OK,    32'h0,         6'd0, 1'b1}},
    '{FUNC_APPEND, 3'd0, 32'h5A5A_5A5A, 1'b1, '{ST_OK,    32'h0,         6'd0, 1'b1}},
    '{FUNC_LIST,   3'd0, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0,         6'd0, 1'b0}},
    '{FUNC_POP,    3'd0, 32'h1234_5678, 1'b1, '{ST_OK,    32'h0,         6'd0, 1'b1}},
    '{FUNC_LIST,   3'd0, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0,         6'd0, 1'b0}},
    '{FUNC_POP,    3'd7, 32'h0000_0000, 1'b1, '{ST_OK,    32'hA5A5_A5A5, 6'd0, 1'b1}},
    '{FUNC_POP,    3'd7, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0,         6'd0, 1'b1}},
    '{FUNC_UNUSED, 3'd7, 32'h0000_0000, 1'b0, '{ST_OK,    32'h0,         6'd0, 1'b0}},
    '{FUNC_APPEND, 3'd3, 32'h0000_0001, 1'b1, '{ST_OK,    32'h0,         6'd0, 1'b1}},
    '{FUNC_LIST,   3'd3, 32'h0000_0000, 1'b1, '{ST_OK,    32'h0000_0001, 6'd1, 1'b1}},
    '{FUNC_POP,    3'd3, 32'h0000_0000, 1'b1, '{ST_OK,    32'h0000_0001, 6'd0, 1'b1}},
    '{FUNC_POP,    3'd0, 32'h0000_0000, 1'b1, '{ST_OK,    32'hFFFF_FFFF, 6'd0, 1'b1}},
    '{FUNC_POP,    3'd0, 32'h0000_0000, 1'b1, '{ST_OK,    32'h5A5A_5A5A, 6'd0, 1'b1}},
    '{FUNC_LIST,   3'd0, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0,         6'd0, 1'b1}},
    '{FUNC_APPEND, 3'd5, 32'h8000_0000, 1'b1, '{ST_OK,    32'h0,         6'd0, 1'b1}}
  };

  // Register settings of the random phases, and the commands in each.
  localparam int N_PHASES = 6;
  localparam logic [CFG_BITS-1:0] PHASE_CFG[N_PHASES] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd6, 4'd8};
  localparam int PHASE_LEN[N_PHASES] = '{30, 12, 40, 30, 30, 40};

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [FUNC_BITS-1:0]   func_i;
  logic [SEL_BITS-1:0]    queue_sel_i;
  logic [TAG_IO_BITS-1:0] tag_in_i;
  logic                   cfg_we_i;
  logic [CFG_BITS-1:0]    cfg_data_i;
  logic                   done_o;
  logic [STATUS_BITS-1:0] status_o;
  logic [TAG_IO_BITS-1:0] tag_out_o;
  logic [POS_BITS-1:0]    position_o;
  logic                   last_o;

  multi_fifo_queue_manager_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .queue_sel_i (queue_sel_i),
    .tag_in_i    (tag_in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .tag_out_o   (tag_out_o),
    .position_o  (position_o),
    .last_o      (last_o)
  );

  // --------------------------------------------------------------------------
  // Behavioral copy of the queues and the pool
  // --------------------------------------------------------------------------
  logic [4:0]             que_head [NUM_Q];
  logic [4:0]             que_tail [NUM_Q];
  bit                     que_live [NUM_Q];
  logic [4:0]             link_next [POOL_SIZE];
  logic [TAG_IO_BITS-1:0] slot_tag [POOL_SIZE];
  logic [4:0]             free_top;
  int unsigned            free_left;
  logic [CFG_BITS-1:0]    active_setting;

  q_result_t pending_outcomes[$];

  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned cfg_writes;
  bit          idle_on;

  function automatic void reset_queue_copy();
    for (int i = 0; i < NUM_Q; i++) begin
      que_head[i] = '0;
      que_tail[i] = '0;
      que_live[i] = 1'b0;
    end
    // Free list chained in index order, last entry wrapping to zero.
    for (int i = 0; i < POOL_SIZE; i++) begin
      link_next[i] = 5'((i + 1) % POOL_SIZE);
      slot_tag[i]  = '0;
    end
    free_top       = '0;
    free_left      = POOL_SIZE;
    active_setting = ACTIVE_RESET;
  endfunction

  function automatic void push_outcome(mfq_status_e st, logic [TAG_IO_BITS-1:0] tag,
                                       logic [POS_BITS-1:0] pos, logic last);
    q_result_t r;
    r.status = st;
    r.tag    = tag;
    r.pos    = pos;
    r.last   = last;
    pending_outcomes.push_back(r);
  endfunction

  // Apply one accepted command to the copy and queue the results it causes.
  function automatic void predict_queue_op(logic [FUNC_BITS-1:0] func,
                                           logic [SEL_BITS-1:0] qsel,
                                           logic [TAG_IO_BITS-1:0] tag);
    int unsigned lim;
    logic [4:0]  e;
    bit          stop;
    lim = (32'(active_setting) < NUM_Q) ? 32'(active_setting) : NUM_Q;
    if (func == FUNC_UNUSED) return;
    if (32'(qsel) >= lim) begin
      push_outcome(ST_BAD_QUEUE, '0, '0, 1'b1);
      return;
    end
    if (func == FUNC_APPEND) begin
      if (free_left == 0) begin
        push_outcome(ST_FULL, '0, '0, 1'b1);
        return;
      end
      e           = free_top;
      free_top    = link_next[e];
      free_left   = free_left - 1;
      slot_tag[e] = tag;
      if (que_live[qsel]) link_next[que_tail[qsel]] = e;
      else que_head[qsel] = e;
      que_tail[qsel] = e;
      que_live[qsel] = 1'b1;
      push_outcome(ST_OK, '0, '0, 1'b1);
      return;
    end
    if (!que_live[qsel]) begin
      push_outcome(ST_EMPTY, '0, '0, 1'b1);
      return;
    end
    if (func == FUNC_POP) begin
      e = que_head[qsel];
      push_outcome(ST_OK, slot_tag[e], '0, 1'b1);
      if (e == que_tail[qsel]) que_live[qsel] = 1'b0;
      else que_head[qsel] = link_next[e];
      // The popped entry goes back on top of the free list.
      link_next[e] = free_top;
      free_top     = e;
      if (free_left < POOL_SIZE) free_left = free_left + 1;
      return;
    end
    // List: walk head to tail, stopping early at the result cap.
    e = que_head[qsel];
    for (int k = 0; k < MAX_RESULTS; k++) begin
      stop = (e == que_tail[qsel]) || (k + 1 >= MAX_RESULTS) || (k + 1 >= POOL_SIZE);
      push_outcome(ST_OK, slot_tag[e], POS_BITS'(k + 1), stop);
      if (stop) break;
      e = link_next[e];
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock, result checking and timeout
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void compare_field(string fname, logic [TAG_IO_BITS-1:0] want,
                                        logic [TAG_IO_BITS-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endfunction

  // Results cannot be held off: take every done_o transfer at the edge that ends it.
  always @(posedge clk_i) begin
    q_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none, %s %0d tag %0h pos %0d last %0d",
                   $time, "got status", status_o, tag_out_o, position_o, last_o);
      end else begin
        want = pending_outcomes.pop_front();
        compare_field("status",   TAG_IO_BITS'(want.status), TAG_IO_BITS'(status_o));
        compare_field("tag_out",  want.tag,                  tag_out_o);
        compare_field("position", TAG_IO_BITS'(want.pos),    TAG_IO_BITS'(position_o));
        compare_field("last",     TAG_IO_BITS'(want.last),   TAG_IO_BITS'(last_o));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout at %0t ns with %0d results outstanding", $time, pending_outcomes.size());
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; all of them are entered and left at a rising edge
  // --------------------------------------------------------------------------

  // Drive one command and hold it until the transfer; then predict it.
  task automatic issue_command(input logic [FUNC_BITS-1:0] func,
                               input logic [SEL_BITS-1:0] qsel,
                               input logic [TAG_IO_BITS-1:0] tag,
                               input logic typed, input q_result_t want);
    start_i     <= 1'b1;
    func_i      <= func;
    queue_sel_i <= qsel;
    tag_in_i    <= tag;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    items_sent++;
    predict_queue_op(func, qsel, tag);
    // A hand-typed result stands in for the predicted one.
    if (typed) begin
      void'(pending_outcomes.pop_back());
      pending_outcomes.push_back(want);
    end
  endtask

  // Drop start for a random burst, when idling is on for this stretch.
  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic send(input logic [FUNC_BITS-1:0] func, input logic [SEL_BITS-1:0] qsel,
                      input logic [TAG_IO_BITS-1:0] tag);
    sender_gap();
    issue_command(func, qsel, tag, 1'b0, '0);
  endtask

  // Hold off until every pending result is in and the block is quiet.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_outcomes.size() != 0 || busy_o !== 1'b0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_active_queues(input logic [CFG_BITS-1:0] value);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    active_setting  = value;
    cfg_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned lim;
    int unsigned pick;
    int unsigned waited;
    logic [FUNC_BITS-1:0] f;
    logic [SEL_BITS-1:0]  qs;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    func_i      = '0;
    queue_sel_i = '0;
    tag_in_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_data_i  = '0;
    fail_count   = 0;
    items_sent   = 0;
    results_seen = 0;
    cfg_writes   = 0;
    idle_on      = 1'b1;
    reset_queue_copy();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset setting.
    for (int i = 0; i < N_DIRECTED; i++) begin
      sender_gap();
      issue_command(DIRECTED[i].func, DIRECTED[i].qsel, DIRECTED[i].tag,
                    DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Pool exhaustion: queue 5 holds one entry, so 31 more fill the pool.
    for (int i = 0; i < 31; i++) send(FUNC_APPEND, 3'd2, $urandom());
    send(FUNC_APPEND, 3'd4, $urandom());   // pool full
    send(FUNC_LIST,   3'd2, '0);           // 31 entries
    send(FUNC_POP,    3'd5, '0);
    send(FUNC_APPEND, 3'd2, $urandom());
    send(FUNC_LIST,   3'd2, '0);           // 32 entries: tail and cap coincide
    send(FUNC_APPEND, 3'd6, $urandom());   // pool full again
    // Drain queue 2 so the random phases start from an empty pool.
    for (int i = 0; i < 32; i++) send(FUNC_POP, 3'd2, '0);
    send(FUNC_LIST, 3'd2, '0);             // empty

    // Random phases, one per register setting; the last one runs without gaps.
    for (int p = 0; p < N_PHASES; p++) begin
      write_active_queues(PHASE_CFG[p]);
      lim = (32'(PHASE_CFG[p]) < NUM_Q) ? 32'(PHASE_CFG[p]) : NUM_Q;
      for (int i = 0; i < PHASE_LEN[p]; i++) begin
        if (p == N_PHASES - 1) idle_on = 1'b0;
        else if (i % 12 == 0) idle_on = ($urandom_range(0, 2) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 4)       f = FUNC_UNUSED;
        else if (pick < 50) f = FUNC_APPEND;
        else if (pick < 80) f = FUNC_POP;
        else                f = FUNC_LIST;
        // Mostly address live queues; now and then any index at all.
        if (lim > 0 && $urandom_range(0, 99) < 85) qs = SEL_BITS'($urandom_range(0, lim - 1));
        else qs = SEL_BITS'($urandom_range(0, NUM_Q - 1));
        send(f, qs, $urandom());
      end
    end

    start_i <= 1'b0;
    waited = 0;
    while (pending_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (END_QUIET) @(posedge clk_i);
    if (pending_outcomes.size() != 0) begin
      $display("%0t ns: %0d results never arrived, expected next status %0d tag %0h",
               $time, pending_outcomes.size(), pending_outcomes[0].status,
               pending_outcomes[0].tag);
      fail_count += pending_outcomes.size();
    end

    $display("Ran %0d commands and checked %0d results over %0d register settings;",
             items_sent, results_seen, cfg_writes + 1);
    $display("covered empty queues, a full pool, a capped list and rejected indexes.");
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
